>>> hw/rtl/pipr_pkg.sv
// types, constants and edge-test functions for the point-in-polygon block
`timescale 1ns / 1ps
`default_nettype none
package pipr_pkg;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic signed [COORD_W-1:0] RAY_END_RST = COORD_W'(10000);

  // register select is paddr bit 2 (byte address 4*index)
  localparam logic REG_RAY_END_X = 1'b0;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef enum logic [1:0] {
    ORI_ZERO,
    ORI_POS,
    ORI_NEG
  } orient_e;

  // first half of one edge test against the ray
  typedef struct packed {
    logic signed [PROD_W-1:0] p_ab;
    logic signed [PROD_W-1:0] p_aq;
    logic signed [PROD_W-1:0] p_ad;
    orient_e                  o3;
    orient_e                  o4;
    logic                     w1;
    logic                     w2;
    logic                     w3;
    logic                     w4;
  } edge_pre_t;

  typedef struct packed {
    logic hit;
    logic coll;
    logic on_seg;
  } edge_res_t;

  function automatic logic in_range(input logic signed [COORD_W-1:0] v,
                                    input logic signed [COORD_W-1:0] a,
                                    input logic signed [COORD_W-1:0] b);
    return ((v >= a) && (v <= b)) || ((v >= b) && (v <= a));
  endfunction

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] ae;
    logic signed [DIFF_W-1:0] be;
    ae = DIFF_W'(a);
    be = DIFF_W'(b);
    return ae - be;
  endfunction

  // sign of (qx - rx) * (py - qy), no multiply needed
  function automatic orient_e horiz_orient(input logic signed [COORD_W-1:0] qx,
                                           input logic signed [COORD_W-1:0] rx,
                                           input logic signed [COORD_W-1:0] py,
                                           input logic signed [COORD_W-1:0] qy);
    orient_e o;
    if ((qx == rx) || (py == qy)) o = ORI_ZERO;
    else if ((qx < rx) != (py < qy)) o = ORI_NEG;
    else o = ORI_POS;
    return o;
  endfunction

  function automatic orient_e cross_orient(input logic signed [CROSS_W-1:0] c);
    orient_e o;
    if (c == '0) o = ORI_ZERO;
    else if (c < 0) o = ORI_NEG;
    else o = ORI_POS;
    return o;
  endfunction

  // edge a-b against ray from q to (rx, qy): products and box checks
  function automatic edge_pre_t edge_pre(input logic signed [COORD_W-1:0] ax,
                                         input logic signed [COORD_W-1:0] ay,
                                         input logic signed [COORD_W-1:0] bx,
                                         input logic signed [COORD_W-1:0] by,
                                         input logic signed [COORD_W-1:0] qx,
                                         input logic signed [COORD_W-1:0] qy,
                                         input logic signed [COORD_W-1:0] rx);
    logic signed [DIFF_W-1:0] d_abx;
    logic signed [DIFF_W-1:0] d_qby;
    logic signed [DIFF_W-1:0] d_aby;
    logic signed [DIFF_W-1:0] d_qbx;
    logic signed [DIFF_W-1:0] d_rbx;
    edge_pre_t e;
    d_abx = sdiff(ax, bx);
    d_qby = sdiff(qy, by);
    d_aby = sdiff(ay, by);
    d_qbx = sdiff(qx, bx);
    d_rbx = sdiff(rx, bx);
    e.p_ab = PROD_W'(d_abx) * PROD_W'(d_qby);
    e.p_aq = PROD_W'(d_aby) * PROD_W'(d_qbx);
    e.p_ad = PROD_W'(d_aby) * PROD_W'(d_rbx);
    e.o3   = horiz_orient(qx, rx, ay, qy);
    e.o4   = horiz_orient(qx, rx, by, qy);
    e.w1   = in_range(qx, ax, bx) && in_range(qy, ay, by);
    e.w2   = in_range(rx, ax, bx) && in_range(qy, ay, by);
    e.w3   = (ay == qy) && in_range(ax, qx, rx);
    e.w4   = (by == qy) && in_range(bx, qx, rx);
    return e;
  endfunction

  function automatic edge_res_t edge_eval(input edge_pre_t e);
    logic signed [CROSS_W-1:0] c1;
    logic signed [CROSS_W-1:0] c2;
    orient_e o1;
    orient_e o2;
    edge_res_t r;
    c1 = CROSS_W'(e.p_ab) - CROSS_W'(e.p_aq);
    c2 = CROSS_W'(e.p_ab) - CROSS_W'(e.p_ad);
    o1 = cross_orient(c1);
    o2 = cross_orient(c2);
    r.hit = ((o1 != o2) && (e.o3 != e.o4)) ||
            ((o1 == ORI_ZERO) && e.w1) || ((o2 == ORI_ZERO) && e.w2) ||
            ((e.o3 == ORI_ZERO) && e.w3) || ((e.o4 == ORI_ZERO) && e.w4);
    // point collinear with the edge
    r.coll   = (o1 == ORI_ZERO);
    r.on_seg = e.w1;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/point_in_polygon_ray_cast.sv
// point-in-polygon test by ray casting, top level
//
// input channel: kind 0 loads the query point, kind 1 gives the next polygon
// vertex; last marks the final vertex, which closes the polygon to the first.
// one item is taken per cycle while in_stall_o is low; every item runs through
// an input stage (edge products and box checks), an evaluation stage
// (orientations, crossing parity) and, for a last vertex, the result register.
// output channel: one item per polygon, inside_res_o is 1 when the query
// point is inside or on the boundary, 0 for fewer than three vertices.
// throughput: one item per cycle while in_stall_o is low.
// the user writes ray_end_x over the apb port only while idle (no item in
// flight); the block itself does not enforce it. when the receiver stalls,
// the result register holds and the pipeline keeps moving; the input stalls
// only when a second result reaches the result register while the first
// still waits.
// reset: ray_end_x = 10000, query point at the origin, no polygon open.
`timescale 1ns / 1ps
`default_nettype none
module point_in_polygon_ray_cast
  import pipr_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // apb config
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [APB_AW-1:0]         paddr,
  input  wire logic [APB_DW-1:0]         pwdata,
  output logic      [APB_DW-1:0]         prdata,
  output logic                           pready,
  // input channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      kind_i,
  input  wire logic signed [COORD_W-1:0] x_i,
  input  wire logic signed [COORD_W-1:0] y_i,
  input  wire logic                      last_i,
  // output channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           inside_res_o
);

  logic signed [COORD_W-1:0] ray_end_q;
  logic signed [COORD_W-1:0] query_x_q, query_y_q;
  logic signed [COORD_W-1:0] first_x_q, first_y_q;
  logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
  logic [1:0]                seen_q;

  // input stage
  logic                      s1_v_q;
  logic                      s1_kind_q, s1_last_q, s1_has_prev_q, s1_seen3_q;
  logic signed [COORD_W-1:0] s1_vx_q, s1_vy_q, s1_px_q, s1_py_q;
  logic signed [COORD_W-1:0] s1_fx_q, s1_fy_q, s1_qx_q, s1_qy_q;

  // evaluation stage
  logic                      s2_v_q;
  logic                      s2_kind_q, s2_last_q, s2_has_prev_q, s2_seen3_q;
  edge_pre_t                 s2_e1_q, s2_e2_q;

  logic                      parity_q, decided_q, decided_val_q;
  logic                      out_valid_q, out_res_q;

  logic                      blk;
  logic                      in_fire;
  logic                      wr_en;
  edge_pre_t                 e1_pre, e2_pre;
  edge_res_t                 e1_res, e2_res;
  logic                      parity_d, decided_d, decided_val_d, res_d;
  logic                      s2_done;

  // freeze only when a new result meets a full, stalled result register
  assign blk        = s2_v_q && (s2_kind_q == KIND_VERTEX) && s2_last_q &&
                      out_valid_q && out_stall_i;
  assign in_stall_o = blk;
  assign in_fire    = in_valid_i && !blk;
  assign s2_done    = s2_v_q && !blk;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RAY_END_X);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RAY_END_X) begin
      prdata = APB_DW'(ray_end_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_end_q <= RAY_END_RST;
    end else if (wr_en) begin
      ray_end_q <= pwdata[COORD_W-1:0];
    end
  end

  // polygon bookkeeping at accept time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
      seen_q    <= '0;
    end else if (in_fire) begin
      if (kind_i == KIND_QUERY) begin
        query_x_q <= x_i;
        query_y_q <= y_i;
        seen_q    <= '0;
      end else if (last_i) begin
        seen_q <= '0;
      end else if (seen_q != 2'd3) begin
        seen_q <= seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (kind_i == KIND_VERTEX)) begin
      if (seen_q == '0) begin
        first_x_q <= x_i;
        first_y_q <= y_i;
      end
      prev_x_q <= x_i;
      prev_y_q <= y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (!blk) begin
      s1_v_q <= in_fire;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q     <= kind_i;
      s1_last_q     <= last_i;
      s1_vx_q       <= x_i;
      s1_vy_q       <= y_i;
      s1_px_q       <= prev_x_q;
      s1_py_q       <= prev_y_q;
      s1_fx_q       <= (seen_q == '0) ? x_i : first_x_q;
      s1_fy_q       <= (seen_q == '0) ? y_i : first_y_q;
      s1_qx_q       <= query_x_q;
      s1_qy_q       <= query_y_q;
      s1_has_prev_q <= (seen_q != '0);
      s1_seen3_q    <= seen_q[1];
    end
  end

  // edge from previous vertex, and closing edge back to the first
  always_comb begin
    e1_pre = edge_pre(s1_px_q, s1_py_q, s1_vx_q, s1_vy_q, s1_qx_q, s1_qy_q, ray_end_q);
    e2_pre = edge_pre(s1_vx_q, s1_vy_q, s1_fx_q, s1_fy_q, s1_qx_q, s1_qy_q, ray_end_q);
  end

  always_ff @(posedge clk_i) begin
    if (!blk) begin
      s2_kind_q     <= s1_kind_q;
      s2_last_q     <= s1_last_q;
      s2_has_prev_q <= s1_has_prev_q;
      s2_seen3_q    <= s1_seen3_q;
      s2_e1_q       <= e1_pre;
      s2_e2_q       <= e2_pre;
    end
  end

  always_comb begin
    e1_res        = edge_eval(s2_e1_q);
    e2_res        = edge_eval(s2_e2_q);
    // w4 of the first edge is the new vertex lying on the ray
    parity_d      = parity_q ^ s2_e1_q.w4;
    decided_d     = decided_q;
    decided_val_d = decided_val_q;
    res_d         = 1'b0;
    if (s2_has_prev_q && !decided_d && e1_res.hit) begin
      if (e1_res.coll) begin
        decided_d     = 1'b1;
        decided_val_d = e1_res.on_seg;
      end else begin
        parity_d = ~parity_d;
      end
    end
    if (s2_last_q) begin
      if (!decided_d && e2_res.hit) begin
        if (e2_res.coll) begin
          decided_d     = 1'b1;
          decided_val_d = e2_res.on_seg;
        end else begin
          parity_d = ~parity_d;
        end
      end
      res_d         = s2_seen3_q && (decided_d ? decided_val_d : parity_d);
      parity_d      = 1'b0;
      decided_d     = 1'b0;
      decided_val_d = 1'b0;
    end
    if (s2_kind_q == KIND_QUERY) begin
      parity_d      = 1'b0;
      decided_d     = 1'b0;
      decided_val_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q      <= 1'b0;
      decided_q     <= 1'b0;
      decided_val_q <= 1'b0;
    end else if (s2_done) begin
      parity_q      <= parity_d;
      decided_q     <= decided_d;
      decided_val_q <= decided_val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_done && (s2_kind_q == KIND_VERTEX) && s2_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_done && (s2_kind_q == KIND_VERTEX) && s2_last_q) begin
      out_res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_res_q;

endmodule
`default_nettype wire
